@@ src/scaled_glyph_framebuffer_blit_assert.svh @@
// Assertion macros used by the glyph blitter controller.
`ifndef SCALED_GLYPH_FRAMEBUFFER_BLIT_ASSERT_SVH
`define SCALED_GLYPH_FRAMEBUFFER_BLIT_ASSERT_SVH

// Same-cycle implication under reset.
`define SGFB_ASSERT_IMPLY(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error("sgfb: same-cycle check failed");

// Next-cycle implication under reset.
`define SGFB_ASSERT_NEXT(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error("sgfb: next-cycle check failed");

`endif

@@ src/sgfb_pkg.sv @@
// Shared types and constants for the scaled glyph frame buffer blitter.
`default_nettype none

package sgfb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int BUFFER_BYTES  = 1024;
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;

    localparam int INPUT_COLS = 5;
    localparam int COL_BITS   = 7;
    localparam int PEN_STEP   = GLYPH_COLUMNS + 1;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CCNT_W = $clog2(GLYPH_COLUMNS + 1);
    localparam int RCNT_W = $clog2(GLYPH_ROWS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_PLAIN,
        RES_READ,
        RES_DRAWN
    } res_sel_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       string_start;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] scale;
        logic [6:0] glyph_col0;
        logic [6:0] glyph_col1;
        logic [6:0] glyph_col2;
        logic [6:0] glyph_col3;
        logic [6:0] glyph_col4;
        logic [9:0] byte_index;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       glyph_drawn;
        logic [7:0] pen_column;
    } result_t;

    typedef struct packed {
        logic     capture;
        logic     clr_step;
        logic     mem_rd_idx;
        logic     mem_rd_pix;
        logic     mem_wr;
        logic     advance;
        logic     finish_draw;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       stopped;
        logic       clr_last;
        logic       glyph_done;
        logic       pix_write;
    } status_t;

endpackage

`default_nettype wire

@@ src/scaled_glyph_framebuffer_blit.sv @@
// Top level of the scaled glyph frame buffer blitter.
//
//  channel  | ports                   | transfer
//  ---------+-------------------------+------------------------------
//  item     | start, busy, item       | start high while busy low
//  result   | done, result            | done high for one cycle
//
//  After reset the buffer is zeroed by a sweep over all 1024 bytes; busy stays high.
//  Clear sweeps every byte; read fetches one byte; an unused code only responds.
//  Draw: walks each glyph cell, skipping an empty cell or a pixel off screen and
//  plotting each pixel as a read then a write; a stopped string draws nothing. Up to
//  35*scale*scale read-modify-write pairs on the frame buffer memory.
//  The receiver cannot stall; busy stays high until the result cycle ends.
`default_nettype none

module scaled_glyph_framebuffer_blit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sgfb_pkg::item_t   item,
    output logic                   busy,
    output logic                   done,
    output sgfb_pkg::result_t      result
);

    sgfb_pkg::cmd_t    cmd;
    sgfb_pkg::status_t status;

    sgfb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sgfb_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

@@ src/sgfb_datapath.sv @@
// Datapath: frame buffer memory, pen state, glyph walk counters and result register.
`default_nettype none

module sgfb_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sgfb_pkg::item_t  item,
    input  wire sgfb_pkg::cmd_t   cmd,
    output sgfb_pkg::status_t     status,
    output sgfb_pkg::result_t     result
);

    logic [7:0] mem [sgfb_pkg::BUFFER_BYTES];

    logic [7:0]                  rdata_reg;
    logic [9:0]                  idx_reg;
    logic [7:0]                  y_reg;
    logic [3:0]                  scale_reg;
    logic [sgfb_pkg::COL_BITS-1:0] cols_reg [sgfb_pkg::INPUT_COLS];
    logic [7:0]                  pen_reg;
    logic                        stopped_reg;
    logic [sgfb_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [sgfb_pkg::CCNT_W-1:0] c_reg;
    logic [sgfb_pkg::RCNT_W-1:0] r_reg;
    logic [3:0]                  dx_reg;
    logic [3:0]                  dy_reg;
    logic [7:0]                  colbase_reg;
    logic [7:0]                  rowbase_reg;
    sgfb_pkg::result_t           result_reg;

    logic [7:0]                  pen_next;
    logic [7:0]                  pen_adv;
    logic signed [9:0]           stop_bound;
    logic                        stop_cond;
    logic [sgfb_pkg::COL_BITS-1:0] col_sel;
    logic                        cell_bit;
    logic                        cell_on;
    logic [3:0]                  scale_m1;
    logic [7:0]                  px;
    logic [7:0]                  py;
    logic [15:0]                 addr_full;
    logic                        on_screen;
    logic [sgfb_pkg::ADDR_W-1:0] pix_addr;
    logic [7:0]                  pix_mask;
    logic [sgfb_pkg::ADDR_W-1:0] raddr;
    logic [sgfb_pkg::ADDR_W-1:0] waddr;
    logic [7:0]                  wdata;
    logic                        idx_ok;
    logic                        clr_last;

    always_comb
    begin
        col_sel = '0;
        for (int i = 0; i < sgfb_pkg::INPUT_COLS; i++)
        begin
            if (c_reg == sgfb_pkg::CCNT_W'(i))
            begin
                col_sel = cols_reg[i];
            end
        end
        cell_bit = 1'b0;
        for (int j = 0; j < sgfb_pkg::COL_BITS; j++)
        begin
            if (r_reg == sgfb_pkg::RCNT_W'(j) && j < sgfb_pkg::GLYPH_ROWS)
            begin
                cell_bit = col_sel[j];
            end
        end
    end

    assign cell_on  = cell_bit && (scale_reg != 4'd0);
    assign scale_m1 = scale_reg - 4'd1;

    assign px        = colbase_reg + {4'd0, dx_reg};
    assign py        = rowbase_reg + {4'd0, dy_reg};
    assign addr_full = {8'd0, px} + {11'd0, py[7:3]} * 16'(sgfb_pkg::SCREEN_WIDTH);
    assign on_screen = (32'(px) < sgfb_pkg::SCREEN_WIDTH)
                    && (32'(py) < sgfb_pkg::SCREEN_HEIGHT)
                    && (32'(addr_full) < sgfb_pkg::BUFFER_BYTES);
    assign pix_addr  = addr_full[sgfb_pkg::ADDR_W-1:0];
    assign pix_mask  = 8'd1 << py[2:0];

    assign pen_next   = (item.operation == sgfb_pkg::OP_DRAW && item.string_start)
                      ? item.x : pen_reg;
    assign pen_adv    = pen_reg + 8'(sgfb_pkg::PEN_STEP * scale_reg);
    assign stop_bound = $signed(10'(sgfb_pkg::SCREEN_WIDTH)
                      - 10'(sgfb_pkg::GLYPH_COLUMNS * scale_reg));
    assign stop_cond  = $signed({2'b00, pen_adv}) > stop_bound;

    assign idx_ok   = 32'(idx_reg) < sgfb_pkg::BUFFER_BYTES;
    assign clr_last = clr_addr_reg == sgfb_pkg::ADDR_W'(sgfb_pkg::BUFFER_BYTES - 1);

    assign raddr = cmd.mem_rd_idx ? sgfb_pkg::ADDR_W'(idx_reg) : pix_addr;
    assign waddr = cmd.clr_step ? clr_addr_reg : pix_addr;
    assign wdata = cmd.clr_step ? 8'd0 : (rdata_reg | pix_mask);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step || cmd.mem_wr)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_rd_idx || cmd.mem_rd_pix)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg     <= item.byte_index;
            y_reg       <= item.y;
            scale_reg   <= item.scale;
            cols_reg[0] <= item.glyph_col0;
            cols_reg[1] <= item.glyph_col1;
            cols_reg[2] <= item.glyph_col2;
            cols_reg[3] <= item.glyph_col3;
            cols_reg[4] <= item.glyph_col4;
        end
        unique case (cmd.res_sel)
            sgfb_pkg::RES_PLAIN:
            begin
                result_reg.read_data   <= 8'd0;
                result_reg.glyph_drawn <= 1'b0;
                result_reg.pen_column  <= pen_reg;
            end
            sgfb_pkg::RES_READ:
            begin
                result_reg.read_data   <= idx_ok ? rdata_reg : 8'd0;
                result_reg.glyph_drawn <= 1'b0;
                result_reg.pen_column  <= pen_reg;
            end
            sgfb_pkg::RES_DRAWN:
            begin
                result_reg.read_data   <= 8'd0;
                result_reg.glyph_drawn <= 1'b1;
                result_reg.pen_column  <= pen_adv;
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg      <= '0;
            stopped_reg  <= 1'b0;
            clr_addr_reg <= '0;
            c_reg        <= '0;
            r_reg        <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            colbase_reg  <= '0;
            rowbase_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                pen_reg     <= pen_next;
                if (item.operation == sgfb_pkg::OP_DRAW && item.string_start)
                begin
                    stopped_reg <= 1'b0;
                end
                colbase_reg <= pen_next;
                rowbase_reg <= item.y;
                c_reg       <= '0;
                r_reg       <= '0;
                dx_reg      <= '0;
                dy_reg      <= '0;
            end
            if (cmd.finish_draw)
            begin
                pen_reg <= pen_adv;
                if (stop_cond)
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.advance)
            begin
                if (!cell_on || (dx_reg == scale_m1 && dy_reg == scale_m1))
                begin
                    dx_reg <= '0;
                    dy_reg <= '0;
                    if (r_reg == sgfb_pkg::RCNT_W'(sgfb_pkg::GLYPH_ROWS - 1))
                    begin
                        r_reg       <= '0;
                        rowbase_reg <= y_reg;
                        c_reg       <= c_reg + 1'b1;
                        colbase_reg <= colbase_reg + {4'd0, scale_reg};
                    end
                    else
                    begin
                        r_reg       <= r_reg + 1'b1;
                        rowbase_reg <= rowbase_reg + {4'd0, scale_reg};
                    end
                end
                else if (dy_reg == scale_m1)
                begin
                    dy_reg <= '0;
                    dx_reg <= dx_reg + 4'd1;
                end
                else
                begin
                    dy_reg <= dy_reg + 4'd1;
                end
            end
        end
    end

    assign status.op         = item.operation;
    assign status.stopped    = stopped_reg;
    assign status.clr_last   = clr_last;
    assign status.glyph_done = c_reg == sgfb_pkg::CCNT_W'(sgfb_pkg::GLYPH_COLUMNS);
    assign status.pix_write  = cell_on && on_screen;

    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/sgfb_ctrl.sv @@
// Controller state machine sequencing clear, read and glyph draw operations.
`default_nettype none
`include "scaled_glyph_framebuffer_blit_assert.svh"

module sgfb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sgfb_pkg::status_t status,
    output sgfb_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_CLR,
        S_RD,
        S_RD_DATA,
        S_CHK,
        S_PIX,
        S_WR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.res_sel = sgfb_pkg::RES_HOLD;
        state_next = state_reg;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    unique case (status.op)
                        sgfb_pkg::OP_CLEAR: state_next = S_CLR;
                        sgfb_pkg::OP_DRAW:  state_next = S_CHK;
                        sgfb_pkg::OP_READ:  state_next = S_RD;
                        default:
                        begin
                            cmd.res_sel = sgfb_pkg::RES_PLAIN;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    cmd.res_sel = sgfb_pkg::RES_PLAIN;
                    state_next  = S_RESP;
                end
            end
            S_RD:
            begin
                cmd.mem_rd_idx = 1'b1;
                state_next     = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.res_sel = sgfb_pkg::RES_READ;
                state_next  = S_RESP;
            end
            S_CHK:
            begin
                if (status.stopped)
                begin
                    cmd.res_sel = sgfb_pkg::RES_PLAIN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_PIX;
                end
            end
            S_PIX:
            begin
                priority if (status.glyph_done)
                begin
                    cmd.finish_draw = 1'b1;
                    cmd.res_sel     = sgfb_pkg::RES_DRAWN;
                    state_next      = S_RESP;
                end
                else if (status.pix_write)
                begin
                    cmd.mem_rd_pix = 1'b1;
                    state_next     = S_WR;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.advance = 1'b1;
                state_next  = S_PIX;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_RESP;

    `SGFB_ASSERT_IMPLY(a_done_busy, clk, rst_n, done, busy)
    `SGFB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SGFB_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `SGFB_ASSERT_IMPLY(a_write_after_read, clk, rst_n, cmd.mem_wr, $past(cmd.mem_rd_pix))

endmodule

`default_nettype wire

@@ tb/sv/scaled_glyph_framebuffer_blit_test.sv @@
// Testbench for the scaled glyph blitter: directed and random glyph, clear and read traffic.
`timescale 1ns / 1ps

module scaled_glyph_framebuffer_blit_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_COMMANDS = 1250;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP = 100;

    typedef struct {
        sgfb_pkg::item_t payload;
        int              gap;
        bit              drain;
    } pending_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    sgfb_pkg::item_t   item = '0;
    logic              busy;
    logic              done;
    sgfb_pkg::result_t result;

    pending_cmd_t      queued_commands[$];
    sgfb_pkg::result_t awaited_results[$];

    logic [7:0] shadow_pixels [sgfb_pkg::BUFFER_BYTES];
    logic [7:0] shadow_pen;
    logic       shadow_stopped;

    bit     took_item;
    int     hold_cycles;
    int     issued_count;
    int     accepted_count;
    int     error_count;
    int     burst_left;
    longint cycle_count;
    longint cycle_budget = 1200;

    scaled_glyph_framebuffer_blit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string what);
        if (error_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic void set_pixel(int px, int py);
        logic [7:0] col;
        logic [7:0] row;
        int         addr;
        col = px[7:0];
        row = py[7:0];
        addr = int'(col) + int'(row >> 3) * sgfb_pkg::SCREEN_WIDTH;
        if (col < sgfb_pkg::SCREEN_WIDTH && row < sgfb_pkg::SCREEN_HEIGHT
            && addr < sgfb_pkg::BUFFER_BYTES)
            shadow_pixels[addr][row[2:0]] = 1'b1;
    endfunction

    function automatic sgfb_pkg::result_t run_command(sgfb_pkg::item_t cmd);
        sgfb_pkg::result_t outcome;
        logic [6:0]        glyph [sgfb_pkg::GLYPH_COLUMNS];
        int                s;
        outcome = '0;
        case (cmd.operation)
            sgfb_pkg::OP_CLEAR:
                foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
            sgfb_pkg::OP_DRAW:
            begin
                if (cmd.string_start)
                begin
                    shadow_pen = cmd.x;
                    shadow_stopped = 1'b0;
                end
                if (!shadow_stopped)
                begin
                    glyph = '{cmd.glyph_col0, cmd.glyph_col1, cmd.glyph_col2,
                              cmd.glyph_col3, cmd.glyph_col4};
                    s = cmd.scale;
                    for (int c = 0; c < sgfb_pkg::GLYPH_COLUMNS; c++)
                        for (int r = 0; r < sgfb_pkg::GLYPH_ROWS; r++)
                            if (glyph[c][r])
                                for (int dx = 0; dx < s; dx++)
                                    for (int dy = 0; dy < s; dy++)
                                        set_pixel(shadow_pen + c * s + dx, cmd.y + r * s + dy);
                    shadow_pen = 8'(shadow_pen + sgfb_pkg::PEN_STEP * s);
                    if (int'(shadow_pen) > sgfb_pkg::SCREEN_WIDTH - sgfb_pkg::GLYPH_COLUMNS * s)
                        shadow_stopped = 1'b1;
                    outcome.glyph_drawn = 1'b1;
                end
            end
            sgfb_pkg::OP_READ:
                if (cmd.byte_index < sgfb_pkg::BUFFER_BYTES)
                    outcome.read_data = shadow_pixels[cmd.byte_index];
            default: ;
        endcase
        outcome.pen_column = shadow_pen;
        return outcome;
    endfunction

    function automatic sgfb_pkg::item_t random_item();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(sgfb_pkg::item_t)-1:0];
    endfunction

    function automatic sgfb_pkg::item_t plain_cmd(logic [1:0] op, logic [9:0] idx);
        sgfb_pkg::item_t cmd;
        cmd = random_item();
        cmd.operation = op;
        cmd.byte_index = idx;
        return cmd;
    endfunction

    function automatic sgfb_pkg::item_t draw_cmd(bit first, logic [7:0] px, logic [7:0] py,
                                                 logic [3:0] s, logic [34:0] glyph);
        sgfb_pkg::item_t cmd;
        cmd = random_item();
        cmd.operation = sgfb_pkg::OP_DRAW;
        cmd.string_start = first;
        cmd.x = px;
        cmd.y = py;
        cmd.scale = s;
        {cmd.glyph_col4, cmd.glyph_col3, cmd.glyph_col2, cmd.glyph_col1, cmd.glyph_col0} = glyph;
        return cmd;
    endfunction

    function automatic logic [3:0] pick_scale();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return 4'd0;
        if (roll < 45) return 4'd1;
        if (roll < 78) return 4'd2;
        if (roll < 91) return 4'd3;
        if (roll < 99) return 4'($urandom_range(4, 7));
        return 4'($urandom_range(8, 15));
    endfunction

    function automatic void queue_command(sgfb_pkg::item_t cmd, bit drain);
        pending_cmd_t entry;
        int           s;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
            entry.gap = $urandom_range(1, 12);
        end
        else
            entry.gap = 0;
        burst_left--;
        entry.payload = cmd;
        entry.drain = drain;
        s = cmd.scale;
        case (cmd.operation)
            sgfb_pkg::OP_CLEAR: cycle_budget += 1100;
            sgfb_pkg::OP_DRAW:  cycle_budget += 20 + 105 * s * s;
            default:            cycle_budget += 10;
        endcase
        cycle_budget += entry.gap;
        queued_commands.push_back(entry);
        issued_count++;
    endfunction

    // hold start until the transfer, then advance to the next queued command
    always @(negedge clk)
    begin
        if (rst_n && !(start && !took_item))
        begin
            took_item = 1'b0;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                start <= 1'b0;
            end
            else if (queued_commands.size() == 0)
                start <= 1'b0;
            else if (queued_commands[0].gap > 0)
            begin
                hold_cycles = queued_commands[0].gap - 1;
                queued_commands[0].gap = 0;
                start <= 1'b0;
            end
            else if (queued_commands[0].drain && awaited_results.size() != 0)
                start <= 1'b0;
            else
            begin
                item <= queued_commands[0].payload;
                start <= 1'b1;
                queued_commands.delete(0);
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        sgfb_pkg::result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                    note_error($sformatf("result with nothing pending: %p", result));
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.read_data !== want.read_data)
                        note_error($sformatf("read_data %h, want %h",
                                             result.read_data, want.read_data));
                    if (result.glyph_drawn !== want.glyph_drawn)
                        note_error($sformatf("glyph_drawn %b, want %b",
                                             result.glyph_drawn, want.glyph_drawn));
                    if (result.pen_column !== want.pen_column)
                        note_error($sformatf("pen_column %0d, want %0d",
                                             result.pen_column, want.pen_column));
                end
            end
            if (start && busy === 1'b0)
            begin
                awaited_results.push_back(run_command(item));
                took_item = 1'b1;
                accepted_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000)
        begin
            $display("scaled_glyph_framebuffer_blit verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          roll;
        int          glyph_count;
        int          random_count;
        bit          drain;
        logic [3:0]  s;
        logic [7:0]  pen_start;
        logic [7:0]  row;
        logic [34:0] glyph;

        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
        shadow_pen = '0;
        shadow_stopped = 1'b0;

        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd0), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd1023), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd0, 8'd0, 4'd1, '1), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd0), 1'b0);
        queue_command(draw_cmd(1'b0, 8'd0, 8'd0, 4'd1, 35'h2AAAAAAAA), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd7), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd250, 8'd60, 4'd2, '1), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd898), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd124, 8'd255, 4'd1, '1), 1'b0);
        queue_command(draw_cmd(1'b0, 8'd0, 8'd0, 4'd1, '1), 1'b0);
        queue_command(plain_cmd(OP_UNUSED, 10'd0), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_CLEAR, 10'd0), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd124), 1'b0);
        queue_command(draw_cmd(1'b0, 8'd5, 8'd5, 4'd1, '1), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd10, 8'd3, 4'd0, '1), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd255, 8'd255, 4'd1, '0), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd0, 8'd0, 4'd15, '1), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd0), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd0, 8'd8, 4'd8, 35'h400000001), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd64, 8'd40, 4'd7, 35'h0C3060C18), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd700), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd100, 8'd0, 4'd4, '1), 1'b0);
        queue_command(draw_cmd(1'b1, 8'd0, 8'd16, 4'd3, 35'h1F3E7CF9F), 1'b0);
        queue_command(draw_cmd(1'b0, 8'd77, 8'd16, 4'd3, 35'h7F0000FFF), 1'b0);
        queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'd1023), 1'b0);

        random_count = 0;
        while (random_count < RANDOM_COMMANDS)
        begin
            roll = $urandom_range(99);
            drain = (random_count == 0) || ($urandom_range(199) == 0);
            if (roll < 50)
            begin
                glyph_count = $urandom_range(1, 6);
                pen_start = ($urandom_range(3) == 0) ? 8'($urandom())
                                                     : 8'($urandom_range(0, 90));
                for (int k = 0; k < glyph_count; k++)
                begin
                    s = pick_scale();
                    glyph = 35'({$urandom(), $urandom()});
                    if (s >= 8)
                        glyph = glyph & 35'({$urandom(), $urandom()})
                                      & 35'({$urandom(), $urandom()});
                    row = ($urandom_range(4) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 63));
                    queue_command(draw_cmd(k == 0, (k == 0) ? pen_start : 8'($urandom()),
                                           row, s, glyph), drain && k == 0);
                    random_count++;
                end
            end
            else
            begin
                if (roll < 82)
                    queue_command(plain_cmd(sgfb_pkg::OP_READ, 10'($urandom())), drain);
                else if (roll < 87)
                    queue_command(plain_cmd(sgfb_pkg::OP_CLEAR, 10'($urandom())), drain);
                else if (roll < 97)
                    queue_command(draw_cmd(1'($urandom()), 8'($urandom()), 8'($urandom()),
                                           pick_scale(), 35'({$urandom(), $urandom()})),
                                  drain);
                else
                    queue_command(plain_cmd(OP_UNUSED, 10'($urandom())), drain);
                random_count++;
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < issued_count) @(negedge clk);
        while (awaited_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("scaled_glyph_framebuffer_blit verification clean");
        else
            $display("scaled_glyph_framebuffer_blit verification failed");
        $finish;
    end

endmodule
